// File: rtl/core/mtg_pkg.sv
// Shared types, constants and helper functions of the MT19937 generator.
package mtg_pkg;

  // Generator geometry.
  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned TAP_OFFSET  = 397;
  localparam int unsigned IDX_W       = $clog2(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  // Recurrence and tempering constants.
  localparam logic [31:0] SEED_RESET   = 32'd5489;
  localparam logic [31:0] FILL_MULT    = 32'd1812433253;
  localparam int unsigned FILL_SHIFT   = 30;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  // Configuration space: one register, selected by address bit 2.
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic        REG_SEED_IDX = 1'b0;

  // Remainder unit: one quotient bit per step over the 31-bit dividend.
  localparam int unsigned DVD_W = 31;
  localparam int unsigned SPAN_W = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  // Core sequencer states.
  typedef enum logic [2:0] {
    CORE_FILL_SEED,
    CORE_FILL_MUL,
    CORE_FILL_WR,
    CORE_IDLE,
    CORE_RD_CUR,
    CORE_RD_NXT,
    CORE_RD_TAP,
    CORE_TWIST
  } core_state_e;

  // Request sequencer states of the top level.
  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_GEN,
    CTRL_DIV,
    CTRL_DONE
  } ctrl_state_e;

  // Commands to the state core.
  typedef struct packed {
    logic fill_start;
    logic gen_start;
  } core_ctrl_t;

  // Status of the state core.
  typedef struct packed {
    logic ready;
    logic filling;
    logic done;
  } core_status_t;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Output tempering of one twisted word.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: rtl/core/mtg_if.sv
// Request and response channel interfaces of the MT19937 generator.
interface mtg_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface mtg_rsp_if;
  logic               valid;
  logic               ready;
  logic        [31:0] raw_word;
  logic signed [31:0] ranged_value;
  logic               range_error;

  modport source (output valid, output raw_word, output ranged_value,
                  output range_error, input ready);
  modport sink   (input valid, input raw_word, input ranged_value,
                  input range_error, output ready);
endinterface

// File: rtl/core/mersenne_twister_generator.sv
// Top level of the MT19937 generator: register port, request sequencing, result register.
//
//   channel  dir  handshake              payload
//   req      in   valid / ready          range_low, range_high
//   rsp      out  valid / ready          raw_word, ranged_value, range_error
//   apb      in   psel, penable, pready  paddr, pwrite, pwdata, prdata
//
// A request with a valid range passes through the state core (three reads and a write
// through the single-read-port memory), then starts the remainder unit, runs its
// 31 bit-serial steps and then loads the result register.
// An inverted range skips the remainder unit. The next request can be taken in the
// cycle after the result loads.
// After reset and after every seed write the state memory is filled with no request
// accepted; register writes are taken throughout, and no request is taken
// in the cycle of a seed write.
// A finished result waits in the output register while the next request is accepted;
// a second finished result waits in the sequencer, which then holds off the input.
module mersenne_twister_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mtg_req_if.sink                           req,
  mtg_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mtg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  mtg_pkg::ctrl_state_e  ctrl_q, ctrl_d;
  mtg_pkg::core_ctrl_t   core_ctrl;
  mtg_pkg::core_status_t core_st;
  mtg_pkg::div_status_t  div_st;

  logic [31:0]                  seed_q;
  logic                         cfg_we;
  logic                         req_acc;
  logic                         div_start;
  logic                         out_load;
  logic                         out_free;
  logic [31:0]                  core_word;
  logic [mtg_pkg::DVD_W-1:0]    rem;

  logic signed [31:0]           lo_q;
  logic [mtg_pkg::SPAN_W-1:0]   span_q;
  logic                         err_q;
  logic [mtg_pkg::SPAN_W-1:0]   span_in;
  logic                         err_in;

  logic                         out_valid_q;
  logic [31:0]                  out_raw_q;
  logic signed [31:0]           out_ranged_q;
  logic                         out_err_q;

  // Register port: the seed register sits at index zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == mtg_pkg::REG_SEED_IDX);
  assign prdata = (paddr[2] == mtg_pkg::REG_SEED_IDX) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtg_pkg::SEED_RESET;
    end else if (cfg_we) begin
      seed_q <= pwdata;
    end
  end

  // Span and range check of an incoming request, computed one bit wider.
  assign err_in  = req.range_high < req.range_low;
  assign span_in = mtg_pkg::SPAN_W'({req.range_high[31], req.range_high} -
                                    {req.range_low[31], req.range_low} + 33'd1);

  // Request sequencer: next state.
  always_comb begin
    ctrl_d = ctrl_q;
    case (ctrl_q)
      mtg_pkg::CTRL_IDLE: begin
        if (req_acc) ctrl_d = mtg_pkg::CTRL_GEN;
      end
      mtg_pkg::CTRL_GEN: begin
        if (core_st.done) ctrl_d = err_q ? mtg_pkg::CTRL_DONE : mtg_pkg::CTRL_DIV;
      end
      mtg_pkg::CTRL_DIV: begin
        if (div_st.done) ctrl_d = mtg_pkg::CTRL_DONE;
      end
      mtg_pkg::CTRL_DONE: begin
        if (out_free) ctrl_d = mtg_pkg::CTRL_IDLE;
      end
      default: ctrl_d = mtg_pkg::CTRL_IDLE;
    endcase
  end

  // Request sequencer: outputs. A seed write wins over a request in the same cycle.
  assign out_free = !out_valid_q || rsp.ready;
  always_comb begin
    req.ready            = 1'b0;
    div_start            = 1'b0;
    out_load             = 1'b0;
    core_ctrl.fill_start = cfg_we;
    core_ctrl.gen_start  = 1'b0;
    case (ctrl_q)
      mtg_pkg::CTRL_IDLE: begin
        req.ready           = core_st.ready && !cfg_we;
        core_ctrl.gen_start = req.valid && core_st.ready && !cfg_we;
      end
      mtg_pkg::CTRL_GEN:  div_start = core_st.done && !err_q;
      mtg_pkg::CTRL_DONE: out_load  = out_free;
      default: begin
        div_start = 1'b0;
      end
    endcase
  end
  assign req_acc = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= mtg_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      lo_q   <= req.range_low;
      span_q <= span_in;
      err_q  <= err_in;
    end
    if (out_load) begin
      out_raw_q    <= core_word;
      out_err_q    <= err_q;
      out_ranged_q <= err_q ? 32'sd0 : (lo_q + $signed({1'b0, rem}));
    end
  end

  mtg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_i     (seed_q),
    .ctrl_i     (core_ctrl),
    .status_o   (core_st),
    .raw_word_o (core_word)
  );

  mtg_rng_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (core_word[31:1]),
    .divisor_i   (span_q),
    .remainder_o (rem),
    .status_o    (div_st)
  );

  assign rsp.valid        = out_valid_q;
  assign rsp.raw_word     = out_raw_q;
  assign rsp.ranged_value = out_ranged_q;
  assign rsp.range_error  = out_err_q;

  // No request is taken while the state memory is being filled.
  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> !core_st.filling)
    else $error("request accepted during state fill");

  // A twisted word only arrives while a request waits for it.
  a_core_done_in_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.done |-> (ctrl_q == mtg_pkg::CTRL_GEN))
    else $error("core word finished outside a request");

  // The remainder unit finishes only for a request in the modulo phase.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (ctrl_q == mtg_pkg::CTRL_DIV))
    else $error("remainder finished outside the modulo phase");

  // A seed write sends the core into a fill at once.
  a_seed_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (core_st.filling && !core_st.ready))
    else $error("seed write did not start a fill");

endmodule

// File: rtl/core/mtg_rng_div.sv
// Iterative restoring remainder unit for the ranged result.
module mtg_rng_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mtg_pkg::DVD_W-1:0]          dividend_i,
  input  logic [mtg_pkg::SPAN_W-1:0]         divisor_i,
  output logic [mtg_pkg::DVD_W-1:0]          remainder_o,
  output mtg_pkg::div_status_t               status_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [mtg_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [mtg_pkg::DVD_W-1:0]         dvd_q, dvd_d;
  logic [mtg_pkg::SPAN_W-1:0]        dvs_q, dvs_d;
  logic [mtg_pkg::SPAN_W-1:0]        rem_q, rem_d;
  logic [mtg_pkg::SPAN_W:0]          trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, dvd_q[mtg_pkg::DVD_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = mtg_pkg::SPAN_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[mtg_pkg::SPAN_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mtg_pkg::DIV_CNT_W'(mtg_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  // The remainder never exceeds the 31-bit dividend.
  assign remainder_o     = rem_q[mtg_pkg::DVD_W-1:0];
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

// File: rtl/core/mtg_core.sv
// State memory with the seed fill and the one-word twist sequencer.
module mtg_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           seed_i,
  input  mtg_pkg::core_ctrl_t   ctrl_i,
  output mtg_pkg::core_status_t status_o,
  output logic [31:0]           raw_word_o
);

  localparam int unsigned IW = mtg_pkg::IDX_W;

  mtg_pkg::core_state_e state_q, state_d;

  logic [31:0]   mem [mtg_pkg::STATE_WORDS];
  logic [31:0]   rd_data_q;
  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wdata;
  logic [IW-1:0] raddr;

  logic [IW-1:0] word_idx_q;
  logic [IW-1:0] fill_idx_q;
  logic [31:0]   prev_q;
  logic [31:0]   prod_q;
  logic          cur_hi_q;
  logic [31:0]   mix_q;
  logic [31:0]   raw_q;
  logic          done_q;

  logic [IW-1:0] nxt_idx;
  logic [IW:0]   tap_sum;
  logic [IW-1:0] tap_idx;
  logic [31:0]   fill_word;
  logic [31:0]   twist_word;
  logic [31:0]   fill_mix;

  // Neighbor and tap addresses of the current word.
  assign nxt_idx = (word_idx_q == mtg_pkg::LAST_IDX) ? '0 : word_idx_q + 1'b1;
  assign tap_sum = {1'b0, word_idx_q} + (IW+1)'(mtg_pkg::TAP_OFFSET);
  assign tap_idx = (tap_sum >= (IW+1)'(mtg_pkg::STATE_WORDS)) ?
                   IW'(tap_sum - (IW+1)'(mtg_pkg::STATE_WORDS)) : tap_sum[IW-1:0];

  // Fill recurrence, split around the multiplier register.
  assign fill_mix  = prev_q ^ (prev_q >> mtg_pkg::FILL_SHIFT);
  assign fill_word = prod_q + {{(32-IW){1'b0}}, fill_idx_q};

  // Twist of the current word; the tap word arrives from the memory now.
  assign twist_word = rd_data_q ^ (mix_q >> 1) ^
                      (mix_q[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtg_pkg::CORE_FILL_SEED: state_d = mtg_pkg::CORE_FILL_MUL;
      mtg_pkg::CORE_FILL_MUL:  state_d = mtg_pkg::CORE_FILL_WR;
      mtg_pkg::CORE_FILL_WR: begin
        state_d = (fill_idx_q == mtg_pkg::LAST_IDX) ? mtg_pkg::CORE_IDLE
                                                    : mtg_pkg::CORE_FILL_MUL;
      end
      mtg_pkg::CORE_IDLE: begin
        if (ctrl_i.gen_start) state_d = mtg_pkg::CORE_RD_CUR;
      end
      mtg_pkg::CORE_RD_CUR: state_d = mtg_pkg::CORE_RD_NXT;
      mtg_pkg::CORE_RD_NXT: state_d = mtg_pkg::CORE_RD_TAP;
      mtg_pkg::CORE_RD_TAP: state_d = mtg_pkg::CORE_TWIST;
      mtg_pkg::CORE_TWIST:  state_d = mtg_pkg::CORE_IDLE;
      default:              state_d = mtg_pkg::CORE_FILL_SEED;
    endcase
    if (ctrl_i.fill_start) state_d = mtg_pkg::CORE_FILL_SEED;
  end

  // Memory port controls.
  always_comb begin
    we    = 1'b0;
    waddr = word_idx_q;
    wdata = twist_word;
    raddr = word_idx_q;
    case (state_q)
      mtg_pkg::CORE_FILL_SEED: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed_i;
      end
      mtg_pkg::CORE_FILL_WR: begin
        we    = 1'b1;
        waddr = fill_idx_q;
        wdata = fill_word;
      end
      mtg_pkg::CORE_RD_CUR: raddr = word_idx_q;
      mtg_pkg::CORE_RD_NXT: raddr = nxt_idx;
      mtg_pkg::CORE_RD_TAP: raddr = tap_idx;
      mtg_pkg::CORE_TWIST:  we    = 1'b1;
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // State word memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mtg_pkg::CORE_FILL_SEED;
      word_idx_q <= '0;
      fill_idx_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == mtg_pkg::CORE_TWIST);
      case (state_q)
        mtg_pkg::CORE_FILL_SEED: begin
          word_idx_q <= '0;
          fill_idx_q <= IW'(1);
        end
        mtg_pkg::CORE_FILL_WR: fill_idx_q <= fill_idx_q + 1'b1;
        mtg_pkg::CORE_TWIST:   word_idx_q <= nxt_idx;
        default: begin
          fill_idx_q <= fill_idx_q;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mtg_pkg::CORE_FILL_SEED: prev_q   <= seed_i;
      mtg_pkg::CORE_FILL_MUL:  prod_q   <= fill_mix * mtg_pkg::FILL_MULT;
      mtg_pkg::CORE_FILL_WR:   prev_q   <= fill_word;
      mtg_pkg::CORE_RD_NXT:    cur_hi_q <= rd_data_q[31];
      mtg_pkg::CORE_RD_TAP:    mix_q    <= {cur_hi_q, rd_data_q[30:0]};
      mtg_pkg::CORE_TWIST:     raw_q    <= mtg_pkg::temper(twist_word);
      default: begin
        raw_q <= raw_q;
      end
    endcase
  end

  assign status_o.ready   = (state_q == mtg_pkg::CORE_IDLE);
  assign status_o.filling = (state_q == mtg_pkg::CORE_FILL_SEED) ||
                            (state_q == mtg_pkg::CORE_FILL_MUL) ||
                            (state_q == mtg_pkg::CORE_FILL_WR);
  assign status_o.done    = done_q;
  assign raw_word_o       = raw_q;

endmodule

// File: tb/mersenne_twister_generator_tb.sv
// Self-checking testbench of the MT19937 generator: seeds, ranged requests and result checks.
module mersenne_twister_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mtg_pkg::CFG_ADDR_W-1:0] SEED_ADDR  = mtg_pkg::CFG_ADDR_W'(0);
  localparam logic [mtg_pkg::CFG_ADDR_W-1:0] SPARE_ADDR = mtg_pkg::CFG_ADDR_W'(4);
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned LONG_HOLD   = 400;

  // One expected response transaction.
  typedef struct {
    logic [31:0]        raw;
    logic signed [31:0] ranged;
    logic               err;
  } draw_t;

  // Generator predictor and response checker.
  class twister_check;
    logic [31:0] words [mtg_pkg::STATE_WORDS];
    int unsigned pos;
    logic [31:0] seed_val;
    draw_t       expected_draws [$];
    int unsigned fails;

    // Refill the state array from a new seed, as the block does after reset and a seed write.
    function void reseed(logic [31:0] s);
      logic [31:0] p;
      seed_val = s;
      words[0] = s;
      for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
        p = words[i-1];
        words[i] = mtg_pkg::FILL_MULT * (p ^ (p >> mtg_pkg::FILL_SHIFT)) + 32'(i);
      end
      pos = 0;
    endfunction

    function new();
      fails = 0;
      reseed(mtg_pkg::SEED_RESET);
    endfunction

    // Twist one word in place and return it tempered.
    function logic [31:0] draw_word();
      int unsigned nxt, tap;
      logic [31:0] mix, y;
      nxt = (pos + 1) % mtg_pkg::STATE_WORDS;
      tap = (pos + mtg_pkg::TAP_OFFSET) % mtg_pkg::STATE_WORDS;
      mix = {words[pos][31], words[nxt][30:0]};
      y = words[tap] ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_MATRIX : 32'h0);
      words[pos] = y;
      pos = nxt;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function void fail(string msg);
      fails++;
      if (fails <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // An accepted request: work out the response it must produce.
    function void note_request(logic signed [31:0] lo, logic signed [31:0] hi);
      draw_t  d;
      longint lo64, hi64, span, half, r;
      lo64 = lo;
      hi64 = hi;
      d.raw = draw_word();
      d.ranged = '0;
      d.err = 1'b0;
      if (hi64 < lo64) begin
        d.err = 1'b1;
      end else begin
        // The span reaches 2^32 at full range, so it is kept in 64 bits.
        span = hi64 - lo64 + 1;
        half = longint'(d.raw >> 1);
        r = half % span + lo64;
        d.ranged = r[31:0];
      end
      expected_draws.push_back(d);
    endfunction

    // An accepted response: compare it with the oldest expectation.
    function void check_result(logic [31:0] raw, logic signed [31:0] ranged, logic err);
      draw_t d;
      if (expected_draws.size() == 0) begin
        fail($sformatf("response with no request pending: raw_word %h", raw));
        return;
      end
      d = expected_draws.pop_front();
      if (raw !== d.raw)
        fail($sformatf("raw_word: expected %h, got %h", d.raw, raw));
      if (ranged !== d.ranged)
        fail($sformatf("ranged_value: expected %0d, got %0d", d.ranged, ranged));
      if (err !== d.err)
        fail($sformatf("range_error: expected %b, got %b", d.err, err));
    endfunction

    function int unsigned outstanding();
      return expected_draws.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [mtg_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  mtg_req_if req_ch ();
  mtg_rsp_if rsp_ch ();

  twister_check sb = new();

  bit gaps_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned quiet_cycles = 0;

  mersenne_twister_generator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both channels at the rising edge; responses first, then new requests.
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.raw_word, rsp_ch.ranged_value, rsp_ch.range_error);
    if (req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.range_low, req_ch.range_high);
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("mersenne_twister_generator_tb: errors");
        $finish;
      end
    end
  end

  // Response side: random back-pressure plus an occasional long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= !(gaps_on && ($urandom_range(0, 99) < 14));
      end
    end
  end

  // Offer one request and wait until it is accepted; valid stays high afterwards.
  task automatic send_range(logic signed [31:0] lo, logic signed [31:0] hi);
    if (gaps_on && ($urandom_range(0, 99) < 14)) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every expected response has come.
  task automatic drain(int unsigned tail);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(logic wr, logic [mtg_pkg::CFG_ADDR_W-1:0] addr,
                              logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register while idle, update the predictor, and read the seed back.
  task automatic write_config(logic [mtg_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] value);
    logic [31:0] rd;
    drain(TAIL_CYCLES);
    apb_transfer(1'b1, addr, value, rd);
    if (addr == SEED_ADDR) sb.reseed(value);
    apb_transfer(1'b0, SEED_ADDR, '0, rd);
    if (rd !== sb.seed_val)
      sb.fail($sformatf("seed readback: expected %h, got %h", sb.seed_val, rd));
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    return (v > longint'(INT_MAX)) ? INT_MAX : v[31:0];
  endfunction

  // Random requests, biased toward narrow, full and inverted ranges.
  task automatic random_ranges(int unsigned count);
    logic signed [31:0] lo, hi;
    for (int unsigned n = 0; n < count; n++) begin
      lo = $urandom;
      hi = $urandom;
      case ($urandom_range(0, 9))
        3, 4: hi = clamp32(longint'(lo) + $urandom_range(0, 15));
        5: begin
          lo = INT_MIN;
          hi = INT_MAX;
        end
        6: hi = lo;
        7: hi = clamp32(longint'(lo) + (longint'(1) << $urandom_range(0, 31)) - 1);
        8: hi = (lo == INT_MIN) ? INT_MAX : lo - 1;
        9: if ($urandom_range(0, 1)) lo = INT_MIN; else hi = INT_MAX;
        default: ;
      endcase
      send_range(lo, hi);
      // Now and then the sender waits for the block to empty.
      if ((n % 150 == 149) && $urandom_range(0, 1)) drain(0);
    end
  endtask

  // Main sequence.
  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_ch.valid      = 1'b0;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset seed: extremes, full range and inverted ranges.
    send_range(0, 0);
    send_range(INT_MIN, INT_MAX);
    send_range(INT_MAX, INT_MIN);
    send_range(INT_MAX, INT_MAX);
    send_range(INT_MIN, INT_MIN);
    send_range(1, 0);
    send_range(-1, 0);
    send_range(0, -1);
    send_range(INT_MIN, -1);
    send_range(0, INT_MAX);
    send_range(INT_MIN, 0);
    send_range(INT_MIN + 1, INT_MAX);
    send_range(INT_MIN, INT_MAX - 1);
    send_range(INT_MAX, INT_MAX - 1);
    send_range(INT_MIN + 1, INT_MIN);
    send_range(-5, 5);
    send_range(100, 1000);
    send_range(0, 1);
    send_range(32'shAAAA_AAAA, 32'sh5555_5555);
    send_range(32'sh5555_5555, 32'shAAAA_AAAA);
    // Long enough to wrap the word index past the end of the state array.
    random_ranges(700);

    // Seed zero, with a long response hold-off while requests keep coming.
    write_config(SEED_ADDR, 32'h0);
    hold_request = LONG_HOLD;
    random_ranges(300);

    // All-ones seed, run with no gaps on either side.
    write_config(SEED_ADDR, 32'hffff_ffff);
    gaps_on = 1'b0;
    random_ranges(300);
    drain(0);
    gaps_on = 1'b1;

    // A write to the unused address must leave the sequence running on.
    write_config(SPARE_ADDR, $urandom);
    random_ranges(200);

    // Random seed.
    write_config(SEED_ADDR, $urandom);
    random_ranges(300);

    drain(TAIL_CYCLES);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("mersenne_twister_generator_tb: clean");
    end else begin
      $display("mersenne_twister_generator_tb: errors");
    end
    $finish;
  end

endmodule
